### hw/rtl/lzg_pkg.sv
// Shared types, codes and constants of the LED zone glow engine.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package lzg_pkg;

	localparam int unsigned ZONES_DEF = 4;
	localparam int unsigned CHAIN_DEF = 8;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [23:0] BASE_COLOR_RST  = 24'hFFAA00;
	localparam logic [6:0]  IDLE_PCT_RST    = 7'd5;
	localparam logic [6:0]  FLASH_PCT_RST   = 7'd60;
	localparam logic [15:0] FLASH_DUR_RST   = 16'd150;
	localparam logic [15:0] PERIOD_RST      = 16'd2000;
	localparam logic [15:0] PERIOD_MIN      = 16'd2;
	localparam logic [1:0]  KEY_PRESS       = 2'd1;

	// Divider: 7-bit percent times 16-bit ramp over a 16-bit divisor.
	localparam int unsigned DVS_W = 16;
	localparam int unsigned DIV_W = 23;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

	// Channel / 100 as a multiply by a rounded-up reciprocal.
	localparam int unsigned PCT_SCALE = 100;
	localparam int unsigned RECIP_SH  = 23;
	localparam int unsigned RECIP_W   = 17;
	localparam int unsigned PCT_RECIP = ((1 << RECIP_SH) + PCT_SCALE - 1) / PCT_SCALE;
	localparam int unsigned CHAN_MASK = 'hff;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_KEY     = 3'd1,
		OP_SCENE   = 3'd2,
		OP_BREATHE = 3'd3,
		OP_RENDER  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		SCENE_ACTIVE = 2'd0,
		SCENE_IDLE   = 2'd1,
		SCENE_SLEEP  = 2'd2
	} scene_t;

	typedef enum logic [2:0] {
		CFG_BASE_COLOR = 3'd0,
		CFG_IDLE_PCT   = 3'd1,
		CFG_FLASH_PCT  = 3'd2,
		CFG_FLASH_DUR  = 3'd3,
		CFG_PERIOD     = 3'd4,
		CFG_CODE_TBL   = 3'd5,
		CFG_PIX_TBL    = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TICK_WAIT,
		ST_RND_START,
		ST_MOD_WAIT,
		ST_ENV_START,
		ST_ENV_WAIT,
		ST_PIX_MUL,
		ST_PIX_SCALE,
		ST_PIX_OUT
	} state_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] key_code;
		logic [1:0]  key_value;
		logic        is_key_type;
		logic [1:0]  activity_state;
		logic [15:0] breathe_ms;
	} item_t;

	typedef struct packed {
		logic load_item;
		logic key_apply;
		logic scene_apply;
		logic breathe_apply;
		logic div_mod;
		logic div_env;
		logic tick_commit;
		logic ramp_mul;
		logic base_plain;
		logic base_env;
		logic pix_clear;
		logic pix_mul;
		logic pix_scale;
		logic pix_next;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       sleep_req;
		logic       breathing;
		logic       div_done;
		logic       pix_last;
	} status_t;

	function automatic logic [15:0] zone_code(input logic [63:0] tbl, input int unsigned z);
		logic [63:0] sh;
		sh = tbl >> (16 * z);
		return sh[15:0];
	endfunction

	function automatic logic [2:0] zone_pixel(input logic [11:0] tbl, input int unsigned z);
		logic [11:0] sh;
		sh = tbl >> (3 * z);
		return sh[2:0];
	endfunction

endpackage

### hw/rtl/lzg_if.sv
// Channel interfaces of the glow engine: command items, pixel results, register writes.
// Depends on lzg_pkg.
interface lzg_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [15:0] key_code;
	logic [1:0]  key_value;
	logic        is_key_type;
	logic [1:0]  activity_state;
	logic [15:0] breathe_ms;

	modport source(output valid, operation, key_code, key_value, is_key_type,
		activity_state, breathe_ms, input ready);
	modport sink(input valid, operation, key_code, key_value, is_key_type,
		activity_state, breathe_ms, output ready);
endinterface

interface lzg_pix_if;
	logic       valid;
	logic       ready;
	logic [2:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       busy_res;
	logic       last;

	modport source(output valid, pixel_index, red, green, blue, busy_res, last, input ready);
	modport sink(input valid, pixel_index, red, green, blue, busy_res, last, output ready);
endinterface

interface lzg_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [lzg_pkg::CFG_IDX_W-1:0]  index;
	logic [lzg_pkg::CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### hw/rtl/led_zone_flash_breathe_glow.sv
// Glow engine for a short LED chain: zone flashes, breathe envelope, frame output.
// A tick item runs the 23-step divider once for the phase wrap; key, scene and
// breathe items update registers only, but a sleep scene item also renders a frame. A frame
// runs the shared divider twice while breathing (phase wrap, then envelope percent),
// then each pixel takes a multiply, a reciprocal scale and an output beat, which
// can stall. One item is worked on at a time; cfg writes are taken every cycle;
// the user must keep them to idle periods, as the block itself does not enforce it.
module led_zone_flash_breathe_glow #(
	parameter int unsigned ZONES = lzg_pkg::ZONES_DEF,
	parameter int unsigned CHAIN = lzg_pkg::CHAIN_DEF
) (
	input logic        clk,
	input logic        arst_n,
	lzg_cmd_if.sink    cmd,
	lzg_pix_if.source  pix,
	lzg_cfg_if.sink    cfg
);
	lzg_pkg::cmd_t    ctl_cmd;
	lzg_pkg::status_t ctl_status;
	lzg_pkg::item_t   item;

	assign item.operation      = cmd.operation;
	assign item.key_code       = cmd.key_code;
	assign item.key_value      = cmd.key_value;
	assign item.is_key_type    = cmd.is_key_type;
	assign item.activity_state = cmd.activity_state;
	assign item.breathe_ms     = cmd.breathe_ms;

	assign cfg.ready = 1'b1;

	lzg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_valid (pix.valid),
		.out_ready (pix.ready),
		.status    (ctl_status),
		.cmd       (ctl_cmd)
	);

	lzg_dp #(
		.ZONES (ZONES),
		.CHAIN (CHAIN)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctl_cmd),
		.status      (ctl_status),
		.item        (item),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.pixel_index (pix.pixel_index),
		.red         (pix.red),
		.green       (pix.green),
		.blue        (pix.blue),
		.busy_res    (pix.busy_res),
		.last        (pix.last)
	);
endmodule

### hw/rtl/lzg_div.sv
// Restoring divider, one quotient bit per cycle, shared by phase wrap and envelope.
// Depends on lzg_pkg.
module lzg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [lzg_pkg::DIV_W-1:0]    dividend,
	input  logic [lzg_pkg::DVS_W-1:0]    divisor,
	output logic                         done,
	output logic [lzg_pkg::DIV_W-1:0]    quotient,
	output logic [lzg_pkg::DVS_W-1:0]    remainder
);
	localparam int unsigned W  = lzg_pkg::DIV_W;
	localparam int unsigned DW = lzg_pkg::DVS_W;
	localparam int unsigned CW = lzg_pkg::DIV_CNT_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;

	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider started while busy");
endmodule

### hw/rtl/lzg_dp.sv
// Datapath: registers, countdowns, envelope arithmetic and per-pixel scaling.
// Depends on lzg_pkg and lzg_div.
module lzg_dp #(
	parameter int unsigned ZONES = lzg_pkg::ZONES_DEF,
	parameter int unsigned CHAIN = lzg_pkg::CHAIN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lzg_pkg::cmd_t                   cmd,
	output lzg_pkg::status_t                status,
	input  lzg_pkg::item_t                  item,
	input  logic                            cfg_we,
	input  logic [lzg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lzg_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [2:0]                      pixel_index,
	output logic [7:0]                      red,
	output logic [7:0]                      green,
	output logic [7:0]                      blue,
	output logic                            busy_res,
	output logic                            last
);
	localparam int unsigned PIX_W   = (CHAIN > 1) ? $clog2(CHAIN) : 1;
	localparam int unsigned PIX_X   = (PIX_W < 3) ? 3 : PIX_W;
	localparam int unsigned ZW      = (ZONES > 1) ? $clog2(ZONES) : 1;
	localparam int unsigned SCALE_W = 16 + lzg_pkg::RECIP_W;
	localparam logic [lzg_pkg::RECIP_W-1:0] RECIP_V = lzg_pkg::RECIP_W'(lzg_pkg::PCT_RECIP);
	localparam logic [7:0] CHAN_MASK_V = 8'(lzg_pkg::CHAN_MASK);

	logic [23:0] base_color_q;
	logic [6:0]  idle_pct_q;
	logic [6:0]  flash_pct_q;
	logic [15:0] flash_dur_q;
	logic [15:0] period_q;
	logic [63:0] code_tbl_q;
	logic [11:0] pix_tbl_q;

	lzg_pkg::item_t item_q;
	logic [1:0]  scene_q;
	logic [15:0] phase_q;
	logic [15:0] breathe_rem_q;
	logic [15:0] flash_q [ZONES];

	logic [lzg_pkg::DIV_W-1:0] prod_q;
	logic [7:0]                base_pct_q;
	logic [PIX_W-1:0]          pix_q;
	logic [15:0]               chan_prod_q [3];
	logic [2:0]                pix_index_q;
	logic [7:0]                chan_q [3];
	logic                      busy_q;
	logic                      last_q;

	logic                      div_start;
	logic [lzg_pkg::DIV_W-1:0] div_dvd;
	logic [lzg_pkg::DVS_W-1:0] div_dvs;
	logic                      div_done;
	logic [lzg_pkg::DIV_W-1:0] div_quo;
	logic [lzg_pkg::DVS_W-1:0] div_rem;

	logic [15:0] period_eff;
	logic [15:0] half;
	logic [15:0] ramp;
	logic [16:0] ph_inc;
	logic [15:0] phase_next;
	logic        active;
	logic        any_flash;
	logic        key_ok;
	logic        key_hit;
	logic [ZW-1:0] key_zone;
	logic        flash_hit;
	logic [PIX_X-1:0] pix_x;
	logic [7:0]  pct;
	logic [SCALE_W-1:0] scaled [3];

	always_comb begin
		period_eff = (period_q < lzg_pkg::PERIOD_MIN) ? lzg_pkg::PERIOD_MIN : period_q;
		half       = {1'b0, period_eff[15:1]};
		ramp       = (div_rem < half) ? div_rem : period_eff - div_rem;
		ph_inc     = {1'b0, div_rem} + 17'd1;
		phase_next = (ph_inc >= {1'b0, period_eff}) ? '0 : ph_inc[15:0];
		active     = scene_q == lzg_pkg::SCENE_ACTIVE;
		pix_x      = PIX_X'(pix_q);

		any_flash = 1'b0;
		flash_hit = 1'b0;
		for (int unsigned z = 0; z < ZONES; z++) begin
			if (flash_q[z] != '0) begin
				any_flash = 1'b1;
				if (PIX_X'(lzg_pkg::zone_pixel(pix_tbl_q, z)) == pix_x) begin
					flash_hit = 1'b1;
				end
			end
		end
		flash_hit = flash_hit && active;
		pct = flash_hit ? {1'b0, flash_pct_q} : base_pct_q;

		key_ok = item_q.is_key_type && (item_q.key_value == lzg_pkg::KEY_PRESS) && active;
		key_hit  = 1'b0;
		key_zone = '0;
		for (int z = int'(ZONES) - 1; z >= 0; z--) begin
			if (lzg_pkg::zone_code(code_tbl_q, unsigned'(z)) == item_q.key_code) begin
				key_hit  = 1'b1;
				key_zone = ZW'(z);
			end
		end

		for (int c = 0; c < 3; c++) begin
			scaled[c] = SCALE_W'(chan_prod_q[c]) * SCALE_W'(RECIP_V);
		end
	end

	assign div_start = cmd.div_mod || cmd.div_env;
	assign div_dvd   = cmd.div_env ? prod_q : lzg_pkg::DIV_W'(phase_q);
	assign div_dvs   = cmd.div_env ? half : period_eff;

	lzg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_color_q  <= lzg_pkg::BASE_COLOR_RST;
			idle_pct_q    <= lzg_pkg::IDLE_PCT_RST;
			flash_pct_q   <= lzg_pkg::FLASH_PCT_RST;
			flash_dur_q   <= lzg_pkg::FLASH_DUR_RST;
			period_q      <= lzg_pkg::PERIOD_RST;
			code_tbl_q    <= '0;
			pix_tbl_q     <= '0;
			scene_q       <= lzg_pkg::SCENE_ACTIVE;
			phase_q       <= '0;
			breathe_rem_q <= '0;
			for (int z = 0; z < ZONES; z++) begin
				flash_q[z] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					lzg_pkg::CFG_BASE_COLOR: base_color_q <= cfg_data[23:0];
					lzg_pkg::CFG_IDLE_PCT:   idle_pct_q   <= cfg_data[6:0];
					lzg_pkg::CFG_FLASH_PCT:  flash_pct_q  <= cfg_data[6:0];
					lzg_pkg::CFG_FLASH_DUR:  flash_dur_q  <= cfg_data[15:0];
					lzg_pkg::CFG_PERIOD:     period_q     <= cfg_data[15:0];
					lzg_pkg::CFG_CODE_TBL:   code_tbl_q   <= cfg_data;
					lzg_pkg::CFG_PIX_TBL:    pix_tbl_q    <= cfg_data[11:0];
					default: ;
				endcase
			end
			if (cmd.scene_apply) begin
				scene_q <= item_q.activity_state;
			end
			if (cmd.tick_commit) begin
				phase_q <= phase_next;
			end
			if (cmd.breathe_apply && active) begin
				breathe_rem_q <= item_q.breathe_ms;
			end else if (cmd.tick_commit && breathe_rem_q != '0) begin
				breathe_rem_q <= breathe_rem_q - 16'd1;
			end
			for (int z = 0; z < ZONES; z++) begin
				if (cmd.key_apply && key_ok && key_hit && key_zone == ZW'(z)) begin
					flash_q[z] <= flash_dur_q;
				end else if (cmd.tick_commit && flash_q[z] != '0) begin
					flash_q[z] <= flash_q[z] - 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
		if (cmd.ramp_mul) begin
			prod_q <= lzg_pkg::DIV_W'(flash_pct_q) * lzg_pkg::DIV_W'(ramp);
		end
		if (cmd.base_plain) begin
			base_pct_q <= active ? {1'b0, idle_pct_q} : '0;
		end else if (cmd.base_env) begin
			base_pct_q <= div_quo[7:0];
		end
		if (cmd.pix_clear) begin
			pix_q <= '0;
		end else if (cmd.pix_next) begin
			pix_q <= pix_q + PIX_W'(1);
		end
		if (cmd.pix_mul) begin
			for (int c = 0; c < 3; c++) begin
				chan_prod_q[c] <= 16'(base_color_q[8 * (2 - c) +: 8]) * 16'(pct);
			end
		end
		if (cmd.pix_scale) begin
			for (int c = 0; c < 3; c++) begin
				chan_q[c] <= scaled[c][lzg_pkg::RECIP_SH +: 8] & CHAN_MASK_V;
			end
			pix_index_q <= pix_x[2:0];
			busy_q      <= active && (breathe_rem_q != '0 || any_flash);
			last_q      <= pix_q == PIX_W'(CHAIN - 1);
		end
	end

	assign status.op        = item_q.operation;
	assign status.sleep_req = item_q.activity_state == lzg_pkg::SCENE_SLEEP;
	assign status.breathing = active && breathe_rem_q != '0;
	assign status.div_done  = div_done;
	assign status.pix_last  = pix_q == PIX_W'(CHAIN - 1);

	assign pixel_index = pix_index_q;
	assign red         = chan_q[0];
	assign green       = chan_q[1];
	assign blue        = chan_q[2];
	assign busy_res    = busy_q;
	assign last        = last_q;
endmodule

### hw/rtl/lzg_ctrl.sv
// Controller state machine: sequences item decode, divider runs and the pixel loop.
// Depends on lzg_pkg.
module lzg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  lzg_pkg::status_t status,
	output lzg_pkg::cmd_t    cmd
);
	lzg_pkg::state_t state_q;
	lzg_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lzg_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lzg_pkg::ST_DECODE;
				end
			end
			lzg_pkg::ST_DECODE: begin
				unique case (status.op)
					lzg_pkg::OP_TICK:   state_d = lzg_pkg::ST_TICK_WAIT;
					lzg_pkg::OP_SCENE:
						state_d = status.sleep_req ? lzg_pkg::ST_RND_START : lzg_pkg::ST_IDLE;
					lzg_pkg::OP_RENDER: state_d = lzg_pkg::ST_RND_START;
					default:            state_d = lzg_pkg::ST_IDLE;
				endcase
			end
			lzg_pkg::ST_TICK_WAIT: begin
				if (status.div_done) begin
					state_d = lzg_pkg::ST_IDLE;
				end
			end
			lzg_pkg::ST_RND_START: begin
				state_d = status.breathing ? lzg_pkg::ST_MOD_WAIT : lzg_pkg::ST_PIX_MUL;
			end
			lzg_pkg::ST_MOD_WAIT: begin
				if (status.div_done) begin
					state_d = lzg_pkg::ST_ENV_START;
				end
			end
			lzg_pkg::ST_ENV_START: state_d = lzg_pkg::ST_ENV_WAIT;
			lzg_pkg::ST_ENV_WAIT: begin
				if (status.div_done) begin
					state_d = lzg_pkg::ST_PIX_MUL;
				end
			end
			lzg_pkg::ST_PIX_MUL:   state_d = lzg_pkg::ST_PIX_SCALE;
			lzg_pkg::ST_PIX_SCALE: state_d = lzg_pkg::ST_PIX_OUT;
			lzg_pkg::ST_PIX_OUT: begin
				if (out_ready) begin
					state_d = status.pix_last ? lzg_pkg::ST_IDLE : lzg_pkg::ST_PIX_MUL;
				end
			end
			default: state_d = lzg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			lzg_pkg::ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_item = in_valid;
			end
			lzg_pkg::ST_DECODE: begin
				unique case (status.op)
					lzg_pkg::OP_TICK:    cmd.div_mod       = 1'b1;
					lzg_pkg::OP_KEY:     cmd.key_apply     = 1'b1;
					lzg_pkg::OP_SCENE:   cmd.scene_apply   = 1'b1;
					lzg_pkg::OP_BREATHE: cmd.breathe_apply = 1'b1;
					default: ;
				endcase
			end
			lzg_pkg::ST_TICK_WAIT: cmd.tick_commit = status.div_done;
			lzg_pkg::ST_RND_START: begin
				cmd.div_mod    = status.breathing;
				cmd.base_plain = !status.breathing;
				cmd.pix_clear  = !status.breathing;
			end
			lzg_pkg::ST_MOD_WAIT:  cmd.ramp_mul = status.div_done;
			lzg_pkg::ST_ENV_START: cmd.div_env  = 1'b1;
			lzg_pkg::ST_ENV_WAIT: begin
				cmd.base_env  = status.div_done;
				cmd.pix_clear = status.div_done;
			end
			lzg_pkg::ST_PIX_MUL:   cmd.pix_mul   = 1'b1;
			lzg_pkg::ST_PIX_SCALE: cmd.pix_scale = 1'b1;
			lzg_pkg::ST_PIX_OUT: begin
				out_valid    = 1'b1;
				cmd.pix_next = out_ready && !status.pix_last;
			end
			default: ;
		endcase
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input and output open together");

	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> (state_q == lzg_pkg::ST_TICK_WAIT ||
			state_q == lzg_pkg::ST_MOD_WAIT || state_q == lzg_pkg::ST_ENV_WAIT))
		else $error("divider result with nobody waiting");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && status.pix_last |=> state_q == lzg_pkg::ST_IDLE)
		else $error("frame did not close after last pixel");
endmodule

### dv/lzg_frame_check.sv
// Frame checker for the LED zone glow engine: tracks register writes and command beats,
// predicts every pixel beat, and compares each pixel beat with the oldest prediction.
// Depends on lzg_pkg and the channel interfaces in lzg_if.
module lzg_frame_check (
	input  logic        clk,
	input  logic        arst_n,
	lzg_cmd_if          cmd,
	lzg_pix_if          pix,
	lzg_cfg_if          cfg,
	output int unsigned error_count,
	output int unsigned pixels_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import lzg_pkg::*;

	typedef struct packed {
		logic [2:0] index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       busy;
		logic       last;
	} pixel_t;

	pixel_t frame_q[$];

	logic [23:0] base_color;
	logic [6:0]  idle_pct;
	logic [6:0]  flash_pct;
	logic [15:0] flash_dur;
	logic [15:0] period_reg;
	logic [63:0] code_tbl;
	logic [11:0] pix_tbl;

	logic [1:0]  scene;
	int unsigned ramp_phase;
	int unsigned breathe_left;
	int unsigned flash_left [ZONES_DEF];

	task automatic report_error(input string msg);
		$display("%0t ns frame check: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [2:0] at,
		input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_error($sformatf("pixel %0d %s got %0h want %0h", at, name, got, want));
	endtask

	function automatic int unsigned glow_period();
		return 32'((period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg);
	endfunction

	function automatic logic [7:0] scale_chan(input logic [7:0] chan, input int unsigned pct);
		int unsigned v;
		v = chan * pct / PCT_SCALE;
		return v[7:0];
	endfunction

	task automatic reset_model();
		base_color = BASE_COLOR_RST;
		idle_pct = IDLE_PCT_RST;
		flash_pct = FLASH_PCT_RST;
		flash_dur = FLASH_DUR_RST;
		period_reg = PERIOD_RST;
		code_tbl = '0;
		pix_tbl = '0;
		scene = SCENE_ACTIVE;
		ramp_phase = 0;
		breathe_left = 0;
		foreach (flash_left[z])
			flash_left[z] = 0;
		frame_q.delete();
	endtask

	task automatic push_frame();
		int unsigned pct [CHAIN_DEF];
		int unsigned level;
		int unsigned per;
		int unsigned ph;
		int unsigned half;
		int unsigned ramp;
		int unsigned spot;
		logic        busy;
		pixel_t      px;
		level = 0;
		busy = 1'b0;
		if (scene == SCENE_ACTIVE) begin
			level = 32'(idle_pct);
			if (breathe_left != 0) begin
				per = glow_period();
				ph = ramp_phase % per;
				half = per / 2;
				ramp = (ph < half) ? ph : per - ph;
				level = flash_pct * ramp / half;
				busy = 1'b1;
			end
		end
		foreach (pct[i])
			pct[i] = level;
		if (scene == SCENE_ACTIVE) begin
			for (int z = 0; z < ZONES_DEF; z++) begin
				if (flash_left[z] != 0) begin
					spot = 32'(pix_tbl[3*z +: 3]);
					if (spot < CHAIN_DEF)
						pct[spot] = 32'(flash_pct);
					busy = 1'b1;
				end
			end
		end
		for (int i = 0; i < CHAIN_DEF; i++) begin
			px.index = i[2:0];
			px.red = scale_chan(base_color[23:16], pct[i]);
			px.green = scale_chan(base_color[15:8], pct[i]);
			px.blue = scale_chan(base_color[7:0], pct[i]);
			px.busy = busy;
			px.last = (i == CHAIN_DEF - 1);
			frame_q.push_back(px);
		end
	endtask

	task automatic apply_beat();
		int unsigned per;
		logic        hit;
		hit = 1'b0;
		case (cmd.operation)
			OP_TICK: begin
				per = glow_period();
				ramp_phase = ramp_phase % per + 1;
				if (ramp_phase >= per)
					ramp_phase = 0;
				if (breathe_left != 0)
					breathe_left--;
				foreach (flash_left[z])
					if (flash_left[z] != 0)
						flash_left[z]--;
			end
			OP_KEY: begin
				if (cmd.is_key_type && cmd.key_value == KEY_PRESS && scene == SCENE_ACTIVE) begin
					for (int z = 0; z < ZONES_DEF; z++) begin
						if (!hit && code_tbl[16*z +: 16] == cmd.key_code) begin
							flash_left[z] = 32'(flash_dur);
							hit = 1'b1;
						end
					end
				end
			end
			OP_SCENE: begin
				scene = cmd.activity_state;
				if (scene == SCENE_SLEEP)
					push_frame();
			end
			OP_BREATHE: begin
				if (scene == SCENE_ACTIVE)
					breathe_left = 32'(cmd.breathe_ms);
			end
			OP_RENDER: push_frame();
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			reset_model();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_BASE_COLOR: base_color = cfg.data[23:0];
					CFG_IDLE_PCT:   idle_pct = cfg.data[6:0];
					CFG_FLASH_PCT:  flash_pct = cfg.data[6:0];
					CFG_FLASH_DUR:  flash_dur = cfg.data[15:0];
					CFG_PERIOD:     period_reg = cfg.data[15:0];
					CFG_CODE_TBL:   code_tbl = cfg.data;
					CFG_PIX_TBL:    pix_tbl = cfg.data[11:0];
					default: ;
				endcase
			end
			if (pix.valid && pix.ready) begin
				if (frame_q.size() == 0) begin
					report_error($sformatf("pixel %0d beat with no frame pending",
						pix.pixel_index));
				end else begin
					want = frame_q.pop_front();
					check_field("index", want.index, 8'(pix.pixel_index), 8'(want.index));
					check_field("red", want.index, pix.red, want.red);
					check_field("green", want.index, pix.green, want.green);
					check_field("blue", want.index, pix.blue, want.blue);
					check_field("busy", want.index, 8'(pix.busy_res), 8'(want.busy));
					check_field("last", want.index, 8'(pix.last), 8'(want.last));
				end
			end
			if (cmd.valid && cmd.ready)
				apply_beat();
		end
		pixels_owed = frame_q.size();
	end

endmodule

### dv/tb.sv
// Top of the glow engine testbench: clock, reset, register setup, command and pixel traffic.
// Depends on lzg_pkg, lzg_if, the glow engine and lzg_frame_check, which checks every pixel beat.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lzg_pkg::*;

	localparam int unsigned LIMIT = 500000;
	localparam int unsigned SETTLE = 80;
	localparam int unsigned PHASES = 6;
	localparam int unsigned PHASE_BEATS = 50;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;
	localparam logic [1:0] SCENE_UNDEF = 2'd3;
	localparam logic [1:0] KEY_RELEASE = 2'd0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned errors;
	int unsigned owed;
	int unsigned cycle_count;
	bit          calm;
	logic [63:0] key_codes;

	lzg_cmd_if cmd();
	lzg_pix_if pix();
	lzg_cfg_if cfg();

	led_zone_flash_breathe_glow dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.pix(pix),
		.cfg(cfg)
	);

	lzg_frame_check frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.pix(pix),
		.cfg(cfg),
		.error_count(errors),
		.pixels_owed(owed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT) begin
			$display("led_zone_flash_breathe_glow verification failed");
			$finish;
		end
	end

	function automatic int unsigned pause();
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	function automatic item_t cmd_beat(input logic [2:0] op, input logic [15:0] arg,
		input logic [1:0] kval, input logic ktype);
		item_t it;
		it.operation = op;
		it.key_code = arg;
		it.key_value = kval;
		it.is_key_type = ktype;
		it.activity_state = arg[1:0];
		it.breathe_ms = arg;
		return it;
	endfunction

	function automatic item_t random_beat();
		item_t       it;
		int unsigned pick;
		int unsigned z;
		it.operation = OP_TICK;
		it.key_code = 16'($urandom);
		it.key_value = 2'($urandom);
		it.is_key_type = 1'($urandom);
		it.activity_state = 2'($urandom);
		it.breathe_ms = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			it.operation = OP_TICK;
		end else if (pick < 58) begin
			it.operation = OP_KEY;
			if ($urandom_range(0, 4) != 0) begin
				z = $urandom_range(0, ZONES_DEF - 1);
				it.key_code = key_codes[16*z +: 16];
				it.key_value = KEY_PRESS;
				it.is_key_type = 1'b1;
			end
		end else if (pick < 66) begin
			it.operation = OP_SCENE;
			z = $urandom_range(0, 9);
			it.activity_state = (z < 6) ? SCENE_ACTIVE : (z < 7) ? SCENE_IDLE :
				(z < 9) ? SCENE_SLEEP : SCENE_UNDEF;
		end else if (pick < 75) begin
			it.operation = OP_BREATHE;
			if ($urandom_range(0, 9) < 7)
				it.breathe_ms = 16'($urandom_range(0, 40));
		end else if (pick < 96) begin
			it.operation = OP_RENDER;
		end else begin
			it.operation = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end
		return it;
	endfunction

	function automatic logic [63:0] fresh_codes();
		logic [63:0] t;
		t = {$urandom, $urandom};
		if ($urandom_range(0, 1))
			t[47:32] = t[15:0];
		return t;
	endfunction

	task automatic send_item(input item_t it);
		int unsigned gap;
		gap = pause();
		@(negedge clk);
		if (gap != 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.operation <= it.operation;
		cmd.key_code <= it.key_code;
		cmd.key_value <= it.key_value;
		cmd.is_key_type <= it.is_key_type;
		cmd.activity_state <= it.activity_state;
		cmd.breathe_ms <= it.breathe_ms;
		do @(posedge clk); while (!cmd.ready);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (owed != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_directed();
		send_item(cmd_beat(OP_RENDER, 16'd0, KEY_PRESS, 1'b1));
		drain();
		key_codes = 64'h0000_1234_1234_FFFF;
		write_reg(CFG_BASE_COLOR, 64'hFF_FFFF);
		write_reg(CFG_IDLE_PCT, 64'd100);
		write_reg(CFG_FLASH_DUR, 64'd3);
		write_reg(CFG_PERIOD, 64'd3);
		write_reg(CFG_CODE_TBL, key_codes);
		write_reg(CFG_PIX_TBL, 64'hEC7);
		send_item(cmd_beat(OP_RENDER, 16'd0, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_KEY, 16'hFFFF, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_KEY, 16'h1234, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_KEY, 16'h0000, KEY_RELEASE, 1'b1));
		send_item(cmd_beat(OP_KEY, 16'h0000, KEY_PRESS, 1'b0));
		send_item(cmd_beat(OP_RENDER, 16'd0, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_BREATHE, 16'hFFFF, KEY_PRESS, 1'b1));
		repeat (3) begin
			send_item(cmd_beat(OP_TICK, 16'd0, KEY_PRESS, 1'b1));
			send_item(cmd_beat(OP_RENDER, 16'd0, KEY_PRESS, 1'b1));
		end
		send_item(cmd_beat(OP_SPARE_FIRST, 16'hFFFF, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_SPARE_LAST, 16'd0, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_BREATHE, 16'd0, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_RENDER, 16'd0, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_SCENE, {14'd0, SCENE_IDLE}, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_KEY, 16'hFFFF, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_RENDER, 16'd0, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_SCENE, {14'd0, SCENE_UNDEF}, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_RENDER, 16'd0, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_SCENE, {14'd0, SCENE_SLEEP}, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_SCENE, {14'd0, SCENE_ACTIVE}, KEY_PRESS, 1'b1));
		send_item(cmd_beat(OP_RENDER, 16'd0, KEY_PRESS, 1'b1));
	endtask

	task automatic setup_phase(input int unsigned k);
		logic [23:0] color;
		logic [6:0]  idle;
		logic [6:0]  flash;
		logic [15:0] dur;
		logic [15:0] per;
		logic [11:0] pixmap;
		color = 24'($urandom);
		idle = 7'($urandom_range(0, 100));
		flash = 7'($urandom_range(0, 100));
		dur = 16'($urandom_range(1, 12));
		per = 16'($urandom_range(2, 12));
		pixmap = 12'($urandom);
		key_codes = fresh_codes();
		case (k)
			1: begin
				color = '0;
				idle = '0;
				flash = '0;
				dur = '0;
				per = 16'($urandom_range(0, 1));
				key_codes = '0;
				pixmap = '0;
			end
			2: begin
				color = '1;
				idle = 7'd100;
				flash = 7'd100;
				dur = '1;
				per = '1;
				key_codes = '1;
				pixmap = '1;
			end
			3: begin
				idle = '1;
				flash = '1;
				dur = 16'd4;
				per = 16'd3;
			end
			4: begin
				dur = 16'($urandom_range(0, 30));
				per = 16'($urandom_range(2, 64));
			end
			default: ;
		endcase
		write_reg(CFG_BASE_COLOR, {40'd0, color});
		write_reg(CFG_IDLE_PCT, {57'd0, idle});
		write_reg(CFG_FLASH_PCT, {57'd0, flash});
		write_reg(CFG_FLASH_DUR, {48'd0, dur});
		write_reg(CFG_PERIOD, {48'd0, per});
		write_reg(CFG_CODE_TBL, key_codes);
		write_reg(CFG_PIX_TBL, {52'd0, pixmap});
	endtask

	initial begin
		int unsigned hold;
		pix.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = pause();
			@(negedge clk);
			if (hold != 0) begin
				pix.ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			pix.ready <= 1'b1;
			do @(posedge clk); while (!pix.valid);
		end
	end

	initial begin
		cmd.valid = 1'b0;
		cmd.operation = OP_TICK;
		cmd.key_code = '0;
		cmd.key_value = '0;
		cmd.is_key_type = 1'b0;
		cmd.activity_state = SCENE_ACTIVE;
		cmd.breathe_ms = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		calm = 1'b0;
		key_codes = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int k = 0; k < PHASES; k++) begin
			drain();
			setup_phase(k);
			calm = (k % 3 == 1);
			repeat (PHASE_BEATS) send_item(random_beat());
		end
		drain();
		if (errors == 0 && owed == 0)
			$display("led_zone_flash_breathe_glow verification clean");
		else
			$display("led_zone_flash_breathe_glow verification failed");
		$finish;
	end

endmodule
